### hw/rtl/agi_pkg.sv
package agi_pkg;

    localparam int MAX_POINTS   = 16;
    localparam int IDX_W        = 4;
    localparam int COUNT_W      = 5;
    localparam int QUAT_W       = 16;
    localparam int ANGLE_W      = 16;
    localparam int GAIN_W       = 24;
    localparam int ENTRY_W      = ANGLE_W + GAIN_W;
    localparam int CORDIC_STEPS = 15;
    localparam int ROOT_STEPS   = 31;

    localparam logic [ANGLE_W-1:0] HALF_TURN    = 16'd32768;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQY,
        ST_SQZ,
        ST_MSQ,
        ST_MM,
        ST_ROOT,
        ST_CORDIC,
        ST_ANG,
        ST_LAST_RD,
        ST_LAST,
        ST_SCAN_RD,
        ST_SCAN,
        ST_SEG0_RD,
        ST_SEG0,
        ST_SEG1_RD,
        ST_SEG1,
        ST_MUL0,
        ST_MUL1,
        ST_DIV,
        ST_DONE
    } state_t;

    // atan(2^-i) in pi/32768 units, rounded
    function automatic logic [13:0] atan_step(input logic [3:0] i);
        logic [13:0] r;
        begin
            case (i)
                4'd0:    r = 14'd8192;
                4'd1:    r = 14'd4836;
                4'd2:    r = 14'd2555;
                4'd3:    r = 14'd1297;
                4'd4:    r = 14'd651;
                4'd5:    r = 14'd326;
                4'd6:    r = 14'd163;
                4'd7:    r = 14'd81;
                4'd8:    r = 14'd41;
                4'd9:    r = 14'd20;
                4'd10:   r = 14'd10;
                4'd11:   r = 14'd5;
                4'd12:   r = 14'd3;
                4'd13:   r = 14'd1;
                4'd14:   r = 14'd1;
                default: r = 14'd0;
            endcase
            return r;
        end
    endfunction

endpackage

### hw/rtl/antenna_gain_interpolator.sv
// Load: busy stays low, no result.
// Query: busy is high from start until the done strobe. The longest queries run through the
// 31-step square root, the 15-step CORDIC, the breakpoint scan (a read state and a compare
// state per table entry) and the 24-step divider.
// Result sits on gain_out/angle_out for the single done cycle; it cannot be stalled.
// rst_n (async, active low) clears control state and point_count to 2; the table is not cleared.
module antenna_gain_interpolator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cfg_we,
    input  logic [agi_pkg::COUNT_W-1:0]   cfg_data,
    input  logic                          cmd,
    input  logic [agi_pkg::IDX_W-1:0]     point_index,
    input  logic [agi_pkg::ANGLE_W-1:0]   point_angle_in,
    input  logic [agi_pkg::GAIN_W-1:0]    point_gain_in,
    input  logic signed [agi_pkg::QUAT_W-1:0] quat_w,
    input  logic signed [agi_pkg::QUAT_W-1:0] quat_x,
    input  logic signed [agi_pkg::QUAT_W-1:0] quat_y,
    input  logic signed [agi_pkg::QUAT_W-1:0] quat_z,
    output logic                          done,
    output logic [agi_pkg::GAIN_W-1:0]    gain_out,
    output logic [agi_pkg::ANGLE_W-1:0]   angle_out
);

    import agi_pkg::*;

    state_t state_reg, state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [15:0] ay_reg, ay_next, az_reg, az_next;
    logic [31:0] s_reg, s_next;
    logic        neg_reg, neg_next;
    logic [30:0] m_reg, m_next;
    logic [61:0] v_reg, v_next;
    logic [34:0] rem_reg, rem_next;
    logic [30:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [16:0] a_reg, a_next;
    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic [IDX_W-1:0] idx_reg, idx_next, seg_reg, seg_next;
    logic [ANGLE_W-1:0] a0_reg, a0_next, a1_reg, a1_next;
    logic [GAIN_W-1:0] g0_reg, g0_next, g1_reg, g1_next, gain_reg, gain_next;
    logic [ANGLE_W-1:0] span_reg, span_next, d_reg, d_next;
    logic [40:0] prod_reg, prod_next;
    logic [16:0] drem_reg, drem_next;

    logic [COUNT_W-1:0] n_sat;
    logic [IDX_W-1:0]   last_idx, scan_end, rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [ANGLE_W-1:0] rd_angle;
    logic [GAIN_W-1:0]  rd_gain;
    logic               accept, load_we;
    logic [32:0]        s2;
    logic [34:0]        rem_sh, trial;
    logic signed [33:0] xs, ys;
    logic signed [16:0] atan_s;
    logic [17:0]        dr_sh;

    assign accept   = start && (state_reg == ST_IDLE);
    assign load_we  = accept && (cmd == CMD_LOAD);
    assign rd_angle = rd_data[ENTRY_W-1:GAIN_W];
    assign rd_gain  = rd_data[GAIN_W-1:0];

    always_comb
    begin
        if (count_reg < COUNT_W'(2))
            n_sat = COUNT_W'(2);
        else if (count_reg > COUNT_W'(MAX_POINTS))
            n_sat = COUNT_W'(MAX_POINTS);
        else
            n_sat = count_reg;
    end

    assign last_idx = IDX_W'(n_sat - COUNT_W'(1));
    assign scan_end = IDX_W'(n_sat - COUNT_W'(2));

    agi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (point_index),
        .wdata ({point_angle_in, point_gain_in}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= COUNT_W'(2);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ay_reg    <= ay_next;
        az_reg    <= az_next;
        s_reg     <= s_next;
        neg_reg   <= neg_next;
        m_reg     <= m_next;
        v_reg     <= v_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        cnt_reg   <= cnt_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        a_reg     <= a_next;
        angle_reg <= angle_next;
        idx_reg   <= idx_next;
        seg_reg   <= seg_next;
        a0_reg    <= a0_next;
        a1_reg    <= a1_next;
        g0_reg    <= g0_next;
        g1_reg    <= g1_next;
        gain_reg  <= gain_next;
        span_reg  <= span_next;
        d_reg     <= d_next;
        prod_reg  <= prod_next;
        drem_reg  <= drem_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ay_next    = ay_reg;
        az_next    = az_reg;
        s_next     = s_reg;
        neg_next   = neg_reg;
        m_next     = m_reg;
        v_next     = v_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        a_next     = a_reg;
        angle_next = angle_reg;
        idx_next   = idx_reg;
        seg_next   = seg_reg;
        a0_next    = a0_reg;
        a1_next    = a1_reg;
        g0_next    = g0_reg;
        g1_next    = g1_reg;
        gain_next  = gain_reg;
        span_next  = span_reg;
        d_next     = d_reg;
        prod_next  = prod_reg;
        drem_next  = drem_reg;
        rd_addr    = idx_reg;

        s2     = {s_reg, 1'b0};
        rem_sh = {rem_reg[32:0], v_reg[61:60]};
        trial  = {2'b00, root_reg, 2'b01};
        xs     = x_reg >>> cnt_reg[3:0];
        ys     = y_reg >>> cnt_reg[3:0];
        atan_s = $signed({3'b000, atan_step(cnt_reg[3:0])});
        dr_sh  = {drem_reg, prod_reg[23]};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_QUERY))
                begin
                    ay_next    = quat_y[QUAT_W-1] ? 16'(-quat_y) : 16'(quat_y);
                    az_next    = quat_z[QUAT_W-1] ? 16'(-quat_z) : 16'(quat_z);
                    state_next = ST_SQY;
                end
            end
            ST_SQY:
            begin
                s_next     = 32'(ay_reg * ay_reg);
                state_next = ST_SQZ;
            end
            ST_SQZ:
            begin
                s_next     = s_reg + 32'(az_reg * az_reg);
                state_next = ST_MSQ;
            end
            ST_MSQ:
            begin
                if (s_reg >= 32'h4000_0000)
                begin
                    // cosine saturates at -1
                    angle_next = HALF_TURN;
                    state_next = ST_LAST_RD;
                end
                else
                begin
                    neg_next   = s2 > 33'h0_4000_0000;
                    m_next     = (s2 > 33'h0_4000_0000) ? 31'(s2 - 33'h0_4000_0000)
                                                        : 31'(33'h0_4000_0000 - s2);
                    state_next = ST_MM;
                end
            end
            ST_MM:
            begin
                v_next     = 62'h1000_0000_0000_0000 - 62'(m_reg * m_reg);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                // one root bit per cycle
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[29:0], 1'b0};
                end
                v_next   = {v_reg[59:0], 2'b00};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ROOT_STEPS - 1))
                begin
                    x_next     = $signed({3'b000, m_reg});
                    y_next     = $signed({3'b000, root_next});
                    a_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    a_next = a_reg + atan_s;
                end
                else if (y_reg < 0)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    a_next = a_reg - atan_s;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_ANG;
                end
            end
            ST_ANG:
            begin
                if (a_reg < 0)
                    angle_next = '0;
                else if (a_reg > $signed({1'b0, QUARTER_TURN}))
                    angle_next = QUARTER_TURN;
                else
                    angle_next = ANGLE_W'(a_reg);
                if (neg_reg)
                    angle_next = HALF_TURN - angle_next;
                state_next = ST_LAST_RD;
            end
            ST_LAST_RD:
            begin
                rd_addr    = last_idx;
                state_next = ST_LAST;
            end
            ST_LAST:
            begin
                if (angle_reg >= rd_angle)
                begin
                    gain_next  = rd_gain;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = '0;
                    seg_next   = '0;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (rd_angle <= angle_reg)
                    seg_next = idx_reg;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == scan_end)
                    state_next = ST_SEG0_RD;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_SEG0_RD:
            begin
                rd_addr    = seg_reg;
                state_next = ST_SEG0;
            end
            ST_SEG0:
            begin
                a0_next    = rd_angle;
                g0_next    = rd_gain;
                state_next = ST_SEG1_RD;
            end
            ST_SEG1_RD:
            begin
                rd_addr    = seg_reg + IDX_W'(1);
                state_next = ST_SEG1;
            end
            ST_SEG1:
            begin
                a1_next   = rd_angle;
                g1_next   = rd_gain;
                span_next = rd_angle - a0_reg;
                d_next    = angle_reg - a0_reg;
                if ((angle_reg <= a0_reg) || (rd_angle <= a0_reg))
                begin
                    gain_next  = g0_reg;
                    state_next = ST_DONE;
                end
                else if (angle_reg >= rd_angle)
                begin
                    gain_next  = rd_gain;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                prod_next  = 41'(g0_reg * (span_reg - d_reg));
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                prod_next  = prod_reg + 41'(g1_reg * d_reg) + 41'(span_reg >> 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // quotient fits 24 bits, so the top bits seed the remainder
                state_next = ST_DIV;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // divider set-up on entry and one quotient bit per cycle
        if (state_reg == ST_MUL1)
        begin
            drem_next = 17'((prod_reg + 41'(g1_reg * d_reg) + 41'(span_reg >> 1)) >> 24);
            cnt_next  = '0;
        end
        if (state_reg == ST_DIV)
        begin
            if (dr_sh >= {2'b00, span_reg})
            begin
                drem_next = 17'(dr_sh - {2'b00, span_reg});
                prod_next = {prod_reg[40:24], prod_reg[22:0], 1'b1};
            end
            else
            begin
                drem_next = 17'(dr_sh);
                prod_next = {prod_reg[40:24], prod_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                gain_next  = prod_next[23:0];
                state_next = ST_DONE;
            end
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_DONE);
    assign gain_out  = gain_reg;
    assign angle_out = angle_reg;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a query");

    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_LOAD) |=> !busy)
        else $error("load transfer held the block");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_QUERY) |=> busy)
        else $error("query transfer not started");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (angle_out <= HALF_TURN))
        else $error("angle beyond half turn");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

### hw/rtl/agi_ram.sv
module agi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
